### sv/tss_pkg.sv
// Shared types, constants and helper functions of the tray sorter stepper controller.
package tss_pkg;

   // Field widths of the channels and registers
   localparam int VALUE_BITS     = 10;
   localparam int PAUSE_BITS     = 8;
   localparam int STEP_CFG_BITS  = 8;
   localparam int RUN_BITS       = 9;
   localparam int COIL_BITS      = 6;
   localparam int BIN_BITS       = 2;
   localparam int OUT_COUNT_BITS = 16;
   localparam int NUM_CLASSES    = 4;

   // Default parameter values
   localparam int DEF_RAMP_STEPS = 8;
   localparam int DEF_COUNT_BITS = 16;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALUMINUM_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEEL_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WHITE_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRUISE_PAUSE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUARTER_STEPS  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_STEPS     = 3'd5;

   // Register reset values
   localparam logic [VALUE_BITS-1:0]    RST_ALUMINUM_LIMIT = 10'd400;
   localparam logic [VALUE_BITS-1:0]    RST_STEEL_LIMIT    = 10'd800;
   localparam logic [VALUE_BITS-1:0]    RST_WHITE_LIMIT    = 10'd950;
   localparam logic [PAUSE_BITS-1:0]    RST_CRUISE_PAUSE   = 8'd8;
   localparam logic [STEP_CFG_BITS-1:0] RST_QUARTER_STEPS  = 8'd34;
   localparam logic [STEP_CFG_BITS-1:0] RST_HALF_STEPS     = 8'd84;

   // Request function codes
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SORT = 1'b1;

   // Bin codes
   localparam logic [BIN_BITS-1:0] BIN_BLACK    = 2'd0;
   localparam logic [BIN_BITS-1:0] BIN_WHITE    = 2'd1;
   localparam logic [BIN_BITS-1:0] BIN_STEEL    = 2'd2;
   localparam logic [BIN_BITS-1:0] BIN_ALUMINUM = 2'd3;

   typedef enum logic [1:0] {
      MOVE_NONE,
      MOVE_CW90,
      MOVE_CCW90,
      MOVE_CW180
   } move_type;

   // Tray move by [from bin][to bin]
   localparam move_type MOVE_TABLE [NUM_CLASSES][NUM_CLASSES] = '{
      '{MOVE_NONE,  MOVE_CW180, MOVE_CCW90, MOVE_CW90 },
      '{MOVE_CW180, MOVE_NONE,  MOVE_CW90,  MOVE_CCW90},
      '{MOVE_CW90,  MOVE_CCW90, MOVE_NONE,  MOVE_CW180},
      '{MOVE_CCW90, MOVE_CW90,  MOVE_CW180, MOVE_NONE }
   };

   // Coil drive patterns in clockwise order
   localparam logic [COIL_BITS-1:0] COIL_TABLE [4] = '{6'h30, 6'h06, 6'h28, 6'h05};

   // Ramp pauses in ticks, fastest last
   localparam int RAMP_TABLE_LEN = 8;
   localparam logic [PAUSE_BITS-1:0] RAMP_FLOOR = 8'd8;
   localparam logic [PAUSE_BITS-1:0] RAMP_TABLE [RAMP_TABLE_LEN] =
      '{8'd20, 8'd19, 8'd16, 8'd13, 8'd11, 8'd10, 8'd9, 8'd8};

   typedef struct packed {
      logic [VALUE_BITS-1:0]    aluminum_limit;
      logic [VALUE_BITS-1:0]    steel_limit;
      logic [VALUE_BITS-1:0]    white_limit;
      logic [PAUSE_BITS-1:0]    cruise_pause;
      logic [STEP_CFG_BITS-1:0] quarter_steps;
      logic [STEP_CFG_BITS-1:0] half_steps;
   } cfg_type;

   typedef struct packed {
      logic [COIL_BITS-1:0]      coil_pattern;
      logic                      busy_res;
      logic                      rejected;
      logic [BIN_BITS-1:0]       tray_bin;
      logic [OUT_COUNT_BITS-1:0] black_count;
      logic [OUT_COUNT_BITS-1:0] white_count;
      logic [OUT_COUNT_BITS-1:0] steel_count;
      logic [OUT_COUNT_BITS-1:0] aluminum_count;
   } result_type;

   // Pause of one ramp entry; entries past the table run at the floor
   function automatic logic [PAUSE_BITS-1:0] ramp_pause(input logic [RUN_BITS-1:0] idx);
      logic [PAUSE_BITS-1:0] pause;
      pause = RAMP_FLOOR;
      if (idx < RUN_BITS'(RAMP_TABLE_LEN)) begin
         pause = RAMP_TABLE[idx[2:0]];
      end
      return pause;
   endfunction

   // Pause after step idx of a run: ramp up, cruise, mirrored ramp down
   function automatic logic [PAUSE_BITS-1:0] step_pause(
      input logic [RUN_BITS-1:0]   idx,
      input logic [RUN_BITS-1:0]   run_len,
      input logic [PAUSE_BITS-1:0] cruise,
      input logic [RUN_BITS-1:0]   ramp_len
   );
      logic [PAUSE_BITS-1:0] pause;
      if (idx < ramp_len) begin
         pause = ramp_pause(idx);
      end else if ({1'b0, idx} + {1'b0, ramp_len} >= {1'b0, run_len}) begin
         pause = ramp_pause(run_len - RUN_BITS'(1) - idx);
      end else if (cruise == '0) begin
         pause = PAUSE_BITS'(1);
      end else begin
         pause = cruise;
      end
      return pause;
   endfunction

endpackage

### sv/tss_channels.sv
// Request and response channel interfaces of the tray sorter stepper controller.
interface tss_req_if;
   import tss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic [VALUE_BITS-1:0] item_value;

   modport source (output valid, output func, output item_value, input ready);
   modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface tss_rsp_if;
   import tss_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COIL_BITS-1:0]      coil_pattern;
   logic                      busy_res;
   logic                      rejected;
   logic [BIN_BITS-1:0]       tray_bin;
   logic [OUT_COUNT_BITS-1:0] black_count;
   logic [OUT_COUNT_BITS-1:0] white_count;
   logic [OUT_COUNT_BITS-1:0] steel_count;
   logic [OUT_COUNT_BITS-1:0] aluminum_count;

   modport source (
      output valid, output coil_pattern, output busy_res, output rejected,
      output tray_bin, output black_count, output white_count,
      output steel_count, output aluminum_count, input ready
   );
   modport sink (
      input valid, input coil_pattern, input busy_res, input rejected,
      input tray_bin, input black_count, input white_count,
      input steel_count, input aluminum_count, output ready
   );
endinterface

### sv/tss_csr.sv
// Configuration register bank: thresholds, cruise pause and cruise step counts.
module tss_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [tss_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tss_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output tss_pkg::cfg_type                      cfg
);
   import tss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unused indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALUMINUM_LIMIT: cfg_in.aluminum_limit = VALUE_BITS'(csr_wdata);
            CSR_STEEL_LIMIT:    cfg_in.steel_limit    = VALUE_BITS'(csr_wdata);
            CSR_WHITE_LIMIT:    cfg_in.white_limit    = VALUE_BITS'(csr_wdata);
            CSR_CRUISE_PAUSE:   cfg_in.cruise_pause   = csr_wdata[PAUSE_BITS-1:0];
            CSR_QUARTER_STEPS:  cfg_in.quarter_steps  = csr_wdata[STEP_CFG_BITS-1:0];
            CSR_HALF_STEPS:     cfg_in.half_steps     = csr_wdata[STEP_CFG_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.aluminum_limit <= RST_ALUMINUM_LIMIT;
         cfg_ff.steel_limit    <= RST_STEEL_LIMIT;
         cfg_ff.white_limit    <= RST_WHITE_LIMIT;
         cfg_ff.cruise_pause   <= RST_CRUISE_PAUSE;
         cfg_ff.quarter_steps  <= RST_QUARTER_STEPS;
         cfg_ff.half_steps     <= RST_HALF_STEPS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/tss_core.sv
// Sorting, tray motion and class counters, with the result register.
module tss_core #(
   parameter int RAMP_STEPS = tss_pkg::DEF_RAMP_STEPS,
   parameter int COUNT_BITS = tss_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              item_func,
   input  logic [tss_pkg::VALUE_BITS-1:0]    item_value,
   input  tss_pkg::cfg_type                  cfg,
   output tss_pkg::result_type               result
);
   import tss_pkg::*;

   localparam logic [RUN_BITS-1:0] RAMP_LEN  = RUN_BITS'(RAMP_STEPS);
   localparam logic [RUN_BITS-1:0] RAMP_BOTH = RUN_BITS'(2 * RAMP_STEPS);

   // Motion and counter state
   logic [BIN_BITS-1:0]   bin_ff, bin_in;
   logic [1:0]            phase_ff, phase_in;
   logic [COIL_BITS-1:0]  pattern_ff, pattern_in;
   logic                  moving_ff, moving_in;
   logic                  cw_ff, cw_in;
   logic [RUN_BITS-1:0]   steps_ff, steps_in;
   logic [RUN_BITS-1:0]   run_len_ff, run_len_in;
   logic [PAUSE_BITS-1:0] wait_ff, wait_in;
   logic [COUNT_BITS-1:0] count_ff [NUM_CLASSES];
   logic [COUNT_BITS-1:0] count_in [NUM_CLASSES];

   result_type result_ff, result_in;

   // Per-item decode
   logic [BIN_BITS-1:0]   target;
   move_type              kind;
   logic                  do_sort;
   logic                  do_tick;
   logic                  rejected;
   logic [PAUSE_BITS-1:0] wait_dec;
   logic [RUN_BITS-1:0]   cruise_steps;
   logic                  step_do;
   logic [RUN_BITS-1:0]   step_idx;
   logic                  step_cw;
   logic [RUN_BITS-1:0]   step_run;
   logic [1:0]            step_phase;

   // Classify the reflectance value by the three thresholds
   always_comb begin
      priority if (item_value < cfg.aluminum_limit) begin
         target = BIN_ALUMINUM;
      end else if (item_value < cfg.steel_limit) begin
         target = BIN_STEEL;
      end else if (item_value < cfg.white_limit) begin
         target = BIN_WHITE;
      end else begin
         target = BIN_BLACK;
      end
   end

   assign kind     = MOVE_TABLE[bin_ff][target];
   assign do_sort  = (item_func == FUNC_SORT) && !moving_ff;
   assign do_tick  = (item_func == FUNC_TICK) && moving_ff;
   assign rejected = (item_func == FUNC_SORT) && moving_ff;
   assign wait_dec = (wait_ff == '0) ? wait_ff : wait_ff - PAUSE_BITS'(1);
   assign cruise_steps = (kind == MOVE_CW180) ? RUN_BITS'(cfg.half_steps)
                                              : RUN_BITS'(cfg.quarter_steps);

   // Sequence the run: start on a sort, advance on a tick
   always_comb begin
      bin_in     = bin_ff;
      moving_in  = moving_ff;
      cw_in      = cw_ff;
      steps_in   = steps_ff;
      run_len_in = run_len_ff;
      wait_in    = wait_ff;
      step_do    = 1'b0;
      step_idx   = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         count_in[c] = count_ff[c];
      end
      if (do_sort) begin
         if (count_ff[target] != '1) begin
            count_in[target] = count_ff[target] + COUNT_BITS'(1);
         end
         bin_in = target;
         if (kind != MOVE_NONE) begin
            cw_in      = (kind != MOVE_CCW90);
            run_len_in = RAMP_BOTH + cruise_steps;
            moving_in  = 1'b1;
            steps_in   = run_len_in - RUN_BITS'(1);
            step_do    = 1'b1;
         end
      end else if (do_tick) begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            if (steps_ff == '0) begin
               moving_in = 1'b0;
            end else begin
               step_idx = run_len_ff - steps_ff;
               steps_in = steps_ff - RUN_BITS'(1);
               step_do  = 1'b1;
            end
         end
      end
   end

   // Drive the next coil phase and load its pause
   assign step_cw    = cw_in;
   assign step_run   = run_len_in;
   assign step_phase = step_cw ? phase_ff + 2'd1 : phase_ff - 2'd1;

   always_comb begin
      phase_in   = phase_ff;
      pattern_in = pattern_ff;
      if (step_do) begin
         phase_in   = step_phase;
         pattern_in = COIL_TABLE[step_phase];
      end
   end

   // Assemble the result from the updated state
   always_comb begin
      result_in.coil_pattern   = pattern_in;
      result_in.busy_res       = moving_in;
      result_in.rejected       = rejected;
      result_in.tray_bin       = bin_in;
      result_in.black_count    = OUT_COUNT_BITS'(count_in[BIN_BLACK]);
      result_in.white_count    = OUT_COUNT_BITS'(count_in[BIN_WHITE]);
      result_in.steel_count    = OUT_COUNT_BITS'(count_in[BIN_STEEL]);
      result_in.aluminum_count = OUT_COUNT_BITS'(count_in[BIN_ALUMINUM]);
   end

   // Advance the state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff     <= BIN_BLACK;
         phase_ff   <= '0;
         pattern_ff <= '0;
         moving_ff  <= 1'b0;
         cw_ff      <= 1'b0;
         steps_ff   <= '0;
         run_len_ff <= '0;
         wait_ff    <= '0;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= '0;
         end
      end else if (step_en) begin
         bin_ff     <= bin_in;
         phase_ff   <= phase_in;
         pattern_ff <= pattern_in;
         moving_ff  <= moving_in;
         cw_ff      <= cw_in;
         steps_ff   <= steps_in;
         run_len_ff <= run_len_in;
         wait_ff    <= step_do ? step_pause(step_idx, step_run, cfg.cruise_pause, RAMP_LEN)
                               : wait_in;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            count_ff[c] <= count_in[c];
         end
      end
   end

   // Capture the result
   always_ff @(posedge clock) begin
      if (step_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### sv/tray_sorter_stepper_controller.sv
// Top level of the tray sorter stepper controller: input register, core, response handshake.
//
// Usage:
//   req carries one item per transfer: func selects a one-millisecond tick (0) or a
//   sort request (1) with the item's minimum reflectance in item_value.
//   rsp returns exactly one result per item: the coil pattern applied, busy_res,
//   rejected (sort request while a move runs), the target bin and four saturating
//   class counters.
//   csr_we/csr_index/csr_wdata write the thresholds and move timing; write only
//   while no item is in flight.
// Pipeline and throughput:
//   An item is transferred into the input register and processed from there into
//   the result register, which offers its result; a stalled result holds it back.
//   One item is accepted every cycle while rsp.ready stays high; the state update
//   through the classifier, move table and pause lookup is combinational and keeps up with that rate.
// Reset:
//   Synchronous, active high. Tray at the black bin, coils off, counters zero,
//   registers at their defaults, both channels empty.
// Stall:
//   While rsp.ready is low the result holds; one more item may wait in the input
//   register, then req.ready drops until the result is taken.
module tray_sorter_stepper_controller #(
   parameter int RAMP_STEPS = tss_pkg::DEF_RAMP_STEPS,
   parameter int COUNT_BITS = tss_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tss_req_if.sink                              req,
   tss_rsp_if.source                            rsp,
   input  logic                                 csr_we,
   input  logic [tss_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tss_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import tss_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic                  in_valid_ff, in_valid_in;
   logic                  in_func_ff;
   logic [VALUE_BITS-1:0] in_value_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  advance;

   // Move an item forward when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign in_valid_in  = (req.valid && req.ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   // Hold handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload on transfer
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_func_ff  <= req.func;
         in_value_ff <= req.item_value;
      end
   end

   tss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tss_core #(
      .RAMP_STEPS (RAMP_STEPS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .item_func  (in_func_ff),
      .item_value (in_value_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Drive the response channel
   assign rsp.valid          = out_valid_ff;
   assign rsp.coil_pattern   = result.coil_pattern;
   assign rsp.busy_res       = result.busy_res;
   assign rsp.rejected       = result.rejected;
   assign rsp.tray_bin       = result.tray_bin;
   assign rsp.black_count    = result.black_count;
   assign rsp.white_count    = result.white_count;
   assign rsp.steel_count    = result.steel_count;
   assign rsp.aluminum_count = result.aluminum_count;

endmodule

### sv/tss_checker.sv
// Port-level assertions for the tray sorter stepper controller, bound to the top level.
module tss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [tss_pkg::COIL_BITS-1:0]      rsp_coil_pattern,
   input logic                               rsp_busy_res,
   input logic                               rsp_rejected
);
   import tss_pkg::*;

   // No result is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A rejected request only happens while a move runs, and leaves it running
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejected without busy");

   // While moving a real coil pattern is applied
   a_busy_coil: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_busy_res |->
         (rsp_coil_pattern == COIL_TABLE[0] || rsp_coil_pattern == COIL_TABLE[1] ||
          rsp_coil_pattern == COIL_TABLE[2] || rsp_coil_pattern == COIL_TABLE[3]))
      else $error("busy with invalid coil pattern");

   // With no result waiting, the block takes a request
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coil_pattern))
      else $error("stalled response changed");

endmodule

bind tray_sorter_stepper_controller tss_checker u_tss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_coil_pattern (rsp.coil_pattern),
   .rsp_busy_res     (rsp.busy_res),
   .rsp_rejected     (rsp.rejected)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench of the tray sorter stepper controller: predicts every result and checks it in order.
module tb;
   import tss_pkg::*;

   localparam int unsigned COUNT_TOP = 65535;
   localparam int unsigned RAMP_LEN  = 8;
   localparam int unsigned MAX_PRINT = 50;

   // Indexes that map to no register
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // Tray state tracker: predicts each result and holds those not yet returned
   class tray_tracker;
      logic [VALUE_BITS-1:0]    aluminum_limit, steel_limit, white_limit;
      logic [PAUSE_BITS-1:0]    cruise_pause;
      logic [STEP_CFG_BITS-1:0] quarter_steps, half_steps;
      logic [BIN_BITS-1:0]      bin_now;
      logic [1:0]               phase;
      logic [COIL_BITS-1:0]     coil_now;
      bit                       moving, clockwise;
      int unsigned              steps_left, run_len, ticks_left;
      int unsigned              class_count [NUM_CLASSES];
      result_type               due_results [$];
      int unsigned              errors, items, moves, rejects, checked;

      function new();
         aluminum_limit = 10'd400;
         steel_limit    = 10'd800;
         white_limit    = 10'd950;
         cruise_pause   = 8'd8;
         quarter_steps  = 8'd34;
         half_steps     = 8'd84;
         bin_now        = BIN_BLACK;
         phase          = 2'd0;
         coil_now       = '0;
         moving         = 1'b0;
         clockwise      = 1'b0;
         steps_left     = 0;
         run_len        = 0;
         ticks_left     = 0;
         foreach (class_count[i]) class_count[i] = 0;
         errors = 0; items = 0; moves = 0; rejects = 0; checked = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         unique case (idx)
            CSR_ALUMINUM_LIMIT: aluminum_limit = data;
            CSR_STEEL_LIMIT:    steel_limit    = data;
            CSR_WHITE_LIMIT:    white_limit    = data;
            CSR_CRUISE_PAUSE:   cruise_pause   = data[PAUSE_BITS-1:0];
            CSR_QUARTER_STEPS:  quarter_steps  = data[STEP_CFG_BITS-1:0];
            CSR_HALF_STEPS:     half_steps     = data[STEP_CFG_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [BIN_BITS-1:0] classify(logic [VALUE_BITS-1:0] v);
         if (v < aluminum_limit) return BIN_ALUMINUM;
         if (v < steel_limit)    return BIN_STEEL;
         if (v < white_limit)    return BIN_WHITE;
         return BIN_BLACK;
      endfunction

      function move_type tray_move(logic [BIN_BITS-1:0] from_bin, logic [BIN_BITS-1:0] to_bin);
         if (from_bin == to_bin) return MOVE_NONE;
         unique case ({from_bin, to_bin})
            {BIN_BLACK, BIN_WHITE}, {BIN_WHITE, BIN_BLACK},
            {BIN_STEEL, BIN_ALUMINUM}, {BIN_ALUMINUM, BIN_STEEL}: return MOVE_CW180;
            {BIN_BLACK, BIN_STEEL}, {BIN_WHITE, BIN_ALUMINUM},
            {BIN_STEEL, BIN_WHITE}, {BIN_ALUMINUM, BIN_BLACK}:    return MOVE_CCW90;
            default: return MOVE_CW90;
         endcase
      endfunction

      function logic [COIL_BITS-1:0] coil_for(logic [1:0] p);
         unique case (p)
            2'd0: return 6'h30;
            2'd1: return 6'h06;
            2'd2: return 6'h28;
            default: return 6'h05;
         endcase
      endfunction

      function int unsigned ramp_ticks(int unsigned i);
         unique case (i)
            0: return 20;
            1: return 19;
            2: return 16;
            3: return 13;
            4: return 11;
            5: return 10;
            6: return 9;
            default: return 8;
         endcase
      endfunction

      // Pause after a step: ramp up, cruise, mirrored ramp down
      function int unsigned pause_after(int unsigned idx);
         if (idx < RAMP_LEN) return ramp_ticks(idx);
         if (idx + RAMP_LEN >= run_len) return ramp_ticks(run_len - 1 - idx);
         return (cruise_pause == 0) ? 1 : cruise_pause;
      endfunction

      function void take_step(int unsigned idx);
         phase      = clockwise ? phase + 2'd1 : phase + 2'd3;
         coil_now   = coil_for(phase);
         ticks_left = pause_after(idx);
      endfunction

      // Advance the tray state by one transfer and queue the result it causes
      function void note_item(logic f, logic [VALUE_BITS-1:0] v);
         result_type          want;
         logic [BIN_BITS-1:0] target;
         move_type            kind;
         bit                  rej;
         int unsigned         idx;
         rej = 1'b0;
         items++;
         if (f == FUNC_SORT) begin
            if (moving) begin
               rej = 1'b1;
               rejects++;
            end else begin
               target = classify(v);
               if (class_count[target] < COUNT_TOP) class_count[target]++;
               kind    = tray_move(bin_now, target);
               bin_now = target;
               if (kind != MOVE_NONE) begin
                  clockwise  = (kind != MOVE_CCW90);
                  run_len    = 2 * RAMP_LEN + ((kind == MOVE_CW180) ? half_steps : quarter_steps);
                  moving     = 1'b1;
                  steps_left = run_len - 1;
                  moves++;
                  take_step(0);
               end
            end
         end else if (moving) begin
            if (ticks_left > 0) ticks_left--;
            if (ticks_left == 0) begin
               if (steps_left == 0) begin
                  moving = 1'b0;
               end else begin
                  idx = run_len - steps_left;
                  steps_left--;
                  take_step(idx);
               end
            end
         end
         want.coil_pattern   = coil_now;
         want.busy_res       = moving;
         want.rejected       = rej;
         want.tray_bin       = bin_now;
         want.black_count    = 16'(class_count[BIN_BLACK]);
         want.white_count    = 16'(class_count[BIN_WHITE]);
         want.steel_count    = 16'(class_count[BIN_STEEL]);
         want.aluminum_count = 16'(class_count[BIN_ALUMINUM]);
         due_results.push_back(want);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINT) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task field_check(string name, logic [15:0] want, logic [15:0] seen);
         if (seen !== want)
            report($sformatf("result %0d %s got %0h want %0h", checked, name, seen, want));
      endtask

      // Compare a returned result with the oldest prediction
      task check_result(result_type seen);
         result_type want;
         if (due_results.size() == 0) begin
            report("result returned with no prediction waiting");
            return;
         end
         want = due_results.pop_front();
         checked++;
         field_check("coil_pattern", 16'(want.coil_pattern), 16'(seen.coil_pattern));
         field_check("busy_res", 16'(want.busy_res), 16'(seen.busy_res));
         field_check("rejected", 16'(want.rejected), 16'(seen.rejected));
         field_check("tray_bin", 16'(want.tray_bin), 16'(seen.tray_bin));
         field_check("black_count", want.black_count, seen.black_count);
         field_check("white_count", want.white_count, seen.white_count);
         field_check("steel_count", want.steel_count, seen.steel_count);
         field_check("aluminum_count", want.aluminum_count, seen.aluminum_count);
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   tss_req_if req_if ();
   tss_rsp_if rsp_if ();

   tray_tracker    sb;
   result_type     seen;
   int             burst_left = 0;
   int             stall_span = 0;
   int unsigned    stall_tick = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int unsigned    settings_done = 0;

   tray_sorter_stepper_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Stall the result channel in spans of changing pattern
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(40, 400);
      end else begin
         stall_span--;
      end
      stall_tick++;
      unique case (stall_mode)
         STALL_NONE:     rsp_if.ready = 1'b1;
         STALL_LIGHT:    rsp_if.ready = ($urandom_range(0, 7) != 0);
         STALL_PERIODIC: rsp_if.ready = (stall_tick % 4 == 0);
         default:        rsp_if.ready = ($urandom_range(0, 1) != 0);
      endcase
   end

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         seen.coil_pattern   = rsp_if.coil_pattern;
         seen.busy_res       = rsp_if.busy_res;
         seen.rejected       = rsp_if.rejected;
         seen.tray_bin       = rsp_if.tray_bin;
         seen.black_count    = rsp_if.black_count;
         seen.white_count    = rsp_if.white_count;
         seen.steel_count    = rsp_if.steel_count;
         seen.aluminum_count = rsp_if.aluminum_count;
         sb.check_result(seen);
      end
   end

   // Offer one item, hold it until transfer, then keep the burst going or idle
   task automatic send_item(input logic f, input logic [VALUE_BITS-1:0] v);
      int gap;
      req_if.valid      = 1'b1;
      req_if.func       = f;
      req_if.item_value = v;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_item(f, v);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_if.valid = 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Hold the sender until every predicted result has come back
   task automatic wait_results(input int limit);
      int waited;
      waited = 0;
      req_if.valid = 1'b0;
      while (sb.due_results.size() != 0 && waited < limit) begin
         @(negedge clock);
         waited++;
      end
      if (sb.due_results.size() != 0)
         sb.report($sformatf("%0d results never returned", sb.due_results.size()));
      repeat (3) @(negedge clock);
   endtask

   // Tick until the tray stops, with the odd request that must be turned away
   task automatic finish_move();
      while (sb.moving) begin
         if ($urandom_range(0, 15) == 0) send_item(FUNC_SORT, 10'($urandom_range(0, 1023)));
         else send_item(FUNC_TICK, 10'($urandom_range(0, 1023)));
      end
   endtask

   task automatic sort_and_settle(input logic [VALUE_BITS-1:0] v);
      send_item(FUNC_SORT, v);
      finish_move();
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_reg(idx, data);
   endtask

   // Stop the tray, drain, then load a full register setting
   task automatic configure(input logic [CSR_DATA_BITS-1:0] al, input logic [CSR_DATA_BITS-1:0] st,
                            input logic [CSR_DATA_BITS-1:0] wh, input logic [CSR_DATA_BITS-1:0] pause,
                            input logic [CSR_DATA_BITS-1:0] quarter,
                            input logic [CSR_DATA_BITS-1:0] half);
      finish_move();
      wait_results(20000);
      write_reg(CSR_ALUMINUM_LIMIT, al);
      write_reg(CSR_STEEL_LIMIT, st);
      write_reg(CSR_WHITE_LIMIT, wh);
      write_reg(CSR_CRUISE_PAUSE, pause);
      write_reg(CSR_QUARTER_STEPS, quarter);
      write_reg(CSR_HALF_STEPS, half);
      settings_done++;
   endtask

   // Values on and around the thresholds, the extremes, or anywhere
   function automatic logic [VALUE_BITS-1:0] pick_value();
      unique case ($urandom_range(0, 5))
         0: return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
         1: return sb.aluminum_limit - 10'($urandom_range(0, 1));
         2: return sb.steel_limit - 10'($urandom_range(0, 1));
         3: return sb.white_limit - 10'($urandom_range(0, 1));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   // Mostly requests while idle, mostly ticks while moving
   task automatic random_phase(input int n_items, input bit hold_midway);
      for (int i = 0; i < n_items; i++) begin
         if (hold_midway && i == n_items / 2) wait_results(20000);
         if (sb.moving) begin
            if ($urandom_range(0, 9) == 0) send_item(FUNC_SORT, 10'($urandom_range(0, 1023)));
            else send_item(FUNC_TICK, 10'($urandom_range(0, 1023)));
         end else if ($urandom_range(0, 9) < 6) begin
            send_item(FUNC_SORT, pick_value());
         end else begin
            send_item(FUNC_TICK, 10'($urandom_range(0, 1023)));
         end
      end
   endtask

   initial begin
      #30ms;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      sb                = new();
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_TICK;
      req_if.item_value = '0;
      rsp_if.ready      = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed at the defaults: idle ticks, same-bin sorts on the white threshold
      send_item(FUNC_TICK, 10'd0);
      send_item(FUNC_TICK, 10'd1023);
      send_item(FUNC_SORT, 10'd1023);
      send_item(FUNC_SORT, 10'd950);

      // Short moves with a zero cruise pause, busy rejects along the way
      configure(10'd400, 10'd800, 10'd950, 10'd0, 10'd1, 10'd2);
      sort_and_settle(10'd949);
      send_item(FUNC_SORT, 10'd800);
      sort_and_settle(10'd399);

      // Random traffic across register settings, extremes included
      configure(10'd0, 10'd0, 10'd0, 10'd255, 10'd0, 10'h2FF);
      random_phase(150, 1'b1);
      configure(10'd1023, 10'd1023, 10'd1023, 10'd2, 10'd1, 10'd0);
      random_phase(200, 1'b0);
      configure(10'd300, 10'd600, 10'd900, 10'd3, 10'd0, 10'd1);
      write_reg(CSR_SPARE_LOW, 10'h3FF);
      write_reg(CSR_SPARE_HIGH, 10'h155);
      random_phase(150, 1'b0);
      finish_move();

      wait_results(20000);
      repeat (10) @(negedge clock);

      $display("Covered %0d transfers, %0d results checked, %0d tray moves, %0d busy rejects,",
               sb.items, sb.checked, sb.moves, sb.rejects);
      $display("%0d register settings; counts black %0d white %0d steel %0d aluminum %0d.",
               settings_done, sb.class_count[BIN_BLACK], sb.class_count[BIN_WHITE],
               sb.class_count[BIN_STEEL], sb.class_count[BIN_ALUMINUM]);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### tray_sorter_stepper_controller.f
sv/tss_pkg.sv
sv/tss_channels.sv
sv/tss_csr.sv
sv/tss_core.sv
sv/tray_sorter_stepper_controller.sv
sv/tss_checker.sv
tb/sv/tb.sv
